### hdl/gost_pkg.sv
package gost_pkg;

  localparam int unsigned ROUNDS   = 32;
  localparam int unsigned ROT      = 11;
  localparam int unsigned NKEYREG  = 4;
  localparam int unsigned RND_W    = $clog2(ROUNDS);

  // direction codes (0 encrypt, 1 decrypt)
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // rounds run in forward key order before the reversed tail
  localparam logic [RND_W-1:0] FWD_ENC = RND_W'(24);
  localparam logic [RND_W-1:0] FWD_DEC = RND_W'(8);

  typedef logic [63:0] key_pair_t;
  typedef logic [31:0] half_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
      4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
    '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
      4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
    '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
      4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
    '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
      4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
    '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
      4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
    '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
      4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
    '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
      4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
    '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
      4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
  };

  // key word index for a given round and direction
  function automatic logic [2:0] key_idx(input logic [RND_W-1:0] rnd, input logic kind);
    logic fwd;
    fwd = (kind == KIND_DEC) ? (rnd < FWD_DEC) : (rnd < FWD_ENC);
    return fwd ? rnd[2:0] : ~rnd[2:0];
  endfunction

  // add, s-box per nibble, rotate left
  function automatic half_t round_f(input half_t half, input half_t k);
    half_t sum;
    half_t sub;
    sum = half + k;
    for (int i = 0; i < 8; i++) begin
      sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
    end
    return (sub << ROT) | (sub >> (32 - ROT));
  endfunction

endpackage

### hdl/gost_block_cipher_ecb.sv
// GOST 28147-89 ECB, fully unrolled: one round per pipeline stage.
// Throughput: one request per cycle; busy is never raised, since the
// 32-stage round pipeline takes a new block every cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) clears stage valids and the key to zero.
module gost_block_cipher_ecb (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [63:0]                in_data_block,
  // result channel
  output logic                       out_valid,
  output logic [63:0]                out_result_block,
  // key register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  gost_pkg::key_pair_t        cfg_data
);
  import gost_pkg::*;

  // key store: four 64-bit pairs, word 2i high, 2i+1 low
  key_pair_t key_r [NKEYREG];

  // one register set per round; entry r holds the halves after round r
  half_t n1_r   [ROUNDS];
  half_t n2_r   [ROUNDS];
  logic  kind_r [ROUNDS];
  logic  vld_r  [ROUNDS];

  half_t n1_nxt   [ROUNDS];
  half_t n2_nxt   [ROUNDS];
  logic  kind_nxt [ROUNDS];
  logic  vld_nxt  [ROUNDS];

  logic accept;

  // no back-pressure anywhere: the pipeline always advances
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NKEYREG; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [RND_W-1:0] RND = RND_W'(r);
    half_t     in1;
    half_t     in2;
    logic      knd;
    logic      vin;
    logic [2:0] kidx;
    key_pair_t kpair;
    half_t     kword;

    if (r == 0) begin : g_head
      // N1 is the high half of the incoming block
      assign in1 = in_data_block[63:32];
      assign in2 = in_data_block[31:0];
      assign knd = in_kind;
      assign vin = accept;
    end else begin : g_body
      assign in1 = n1_r[r-1];
      assign in2 = n2_r[r-1];
      assign knd = kind_r[r-1];
      assign vin = vld_r[r-1];
    end

    // encrypt: 0..7 x3 then 7..0; decrypt: 0..7 then 7..0 x3
    assign kidx  = key_idx(RND, knd);
    assign kpair = key_r[kidx[2:1]];
    assign kword = kidx[0] ? kpair[31:0] : kpair[63:32];

    always_comb begin
      n1_nxt[r]   = round_f(in1, kword) ^ in2;
      n2_nxt[r]   = in1;
      kind_nxt[r] = knd;
      vld_nxt[r]  = vin;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[r] <= 1'b0;
      end else begin
        vld_r[r] <= vld_nxt[r];
      end
      n1_r[r]   <= n1_nxt[r];
      n2_r[r]   <= n2_nxt[r];
      kind_r[r] <= kind_nxt[r];
    end
  end

  // final swap undone: N2 high, N1 low
  assign out_valid        = vld_r[ROUNDS-1];
  assign out_result_block = {n2_r[ROUNDS-1], n1_r[ROUNDS-1]};

  // ---------------------------------------------------------------------------
  // checks

  // every result traces back to an accepted request
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ROUNDS))
    else $error("result without matching request");

  // the head stage captures exactly the accepted requests
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (vld_r[0] == $past(start && !busy)))
    else $error("head stage valid mismatch");

  // a valid item in the middle stage moves to the next stage without loss
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ROUNDS/2-1] |=> vld_r[ROUNDS/2])
    else $error("item lost mid-pipeline");

  // reset leaves no strobe behind
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe after reset");

endmodule

### tb/tb_gost_block_cipher_ecb.sv
// Block cipher bench: drives encrypt and decrypt requests into the 32-stage
// round pipeline and checks every strobed result against a local model of
// the GOST Feistel network.
module tb_gost_block_cipher_ecb;
  timeunit 1ns;
  timeprecision 1ps;

  import gost_pkg::*;

  // pipeline depth quoted by the design, plus a little margin
  localparam int LATENCY = 32;
  localparam int TAIL    = LATENCY + 8;

  // key register indexes
  localparam logic [1:0] REG_KEY01 = 2'd0;
  localparam logic [1:0] REG_KEY23 = 2'd1;
  localparam logic [1:0] REG_KEY45 = 2'd2;
  localparam logic [1:0] REG_KEY67 = 2'd3;
  localparam logic [1:0] KEY_REG [4] = '{REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67};

  // substitution rows, row i serves nibble i (own copy, not the package's)
  localparam logic [3:0] SUBST [8][16] = '{
    '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
      4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
    '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
      4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
    '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
      4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
    '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
      4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
    '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
      4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
    '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
      4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
    '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
      4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
    '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
      4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
  };

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
  } block_req_t;

  // DUT signals; the inputs are driven to known values from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_ENC;
  logic [63:0] in_data_block = '0;
  logic        out_valid;
  logic [63:0] out_result_block;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_KEY01;
  key_pair_t   cfg_data = '0;

  // bench state
  key_pair_t   key_pairs [4] = '{default: '0};   // mirror of the key registers
  block_req_t  pending_blocks [$];               // requests not yet offered
  logic [63:0] cipher_due [$];                   // results owed, oldest first
  block_req_t  next_req;
  logic [63:0] want_block;
  int          src_idle_pct = 10;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          fail_count = 0;

  gost_block_cipher_ecb dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_result_block (out_result_block),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Full 32-round network under the mirrored key.
  // Encrypt: words 0..7 three times then 7..0; decrypt: 0..7 once then 7..0 x3.
  // Key addition wraps modulo 2^32.
  function automatic logic [63:0] gost_cipher(input logic kind, input logic [63:0] blk);
    logic [31:0] n1, n2, prev, sum, sub, kw;
    int fwd_rounds;
    int widx;
    n1 = blk[63:32];
    n2 = blk[31:0];
    fwd_rounds = (kind == KIND_DEC) ? 8 : 24;
    for (int r = 0; r < 32; r++) begin
      widx = (r < fwd_rounds) ? (r % 8) : (7 - (r % 8));
      kw   = (widx % 2 == 0) ? key_pairs[widx / 2][63:32] : key_pairs[widx / 2][31:0];
      sum  = n1 + kw;
      for (int i = 0; i < 8; i++) begin
        sub[4*i +: 4] = SUBST[i][sum[4*i +: 4]];
      end
      prev = n1;
      n1   = {sub[20:0], sub[31:21]} ^ n2;   // rotate left by 11
      n2   = prev;
    end
    // last swap undone: N2 high, N1 low
    return {n2, n1};
  endfunction

  task automatic queue_req(input logic kind, input logic [63:0] data);
    pending_blocks.push_back('{kind: kind, data: data});
    queued_count++;
  endtask

  // mostly full-width random blocks, now and then an extreme
  function automatic logic [63:0] pick_block();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2:       return {32'hFFFF_FFFF, 32'h0};
      3:       return {32'h0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random traffic; about a quarter are encrypt-then-decrypt pairs so that
  // the decrypt path sees genuine ciphertext and must give the plaintext back.
  task automatic queue_random(input int n);
    logic [63:0] blk;
    int k;
    k = 0;
    while (k < n) begin
      blk = pick_block();
      if ($urandom_range(99) < 25) begin
        queue_req(KIND_ENC, blk);
        queue_req(KIND_DEC, gost_cipher(KIND_ENC, blk));
        k += 2;
      end else begin
        queue_req($urandom_range(1) ? KIND_DEC : KIND_ENC, blk);
        k++;
      end
    end
  endtask

  // Returns once every queued request has gone in and its result come back.
  // Counters, not queue sizes, so a pop on this very edge cannot fool it.
  task automatic wait_drain();
    do @(posedge clk);
    while (accepted_count != queued_count || cipher_due.size() != 0);
  endtask

  // Write all four key registers back to back; valid stays high throughout.
  // Must be entered just after a rising edge.
  task automatic load_key(input key_pair_t k01, input key_pair_t k23,
                          input key_pair_t k45, input key_pair_t k67);
    key_pair_t pairs [4];
    pairs = '{k01, k23, k45, k67};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= KEY_REG[i];
      cfg_data  <= pairs[i];
      do @(posedge clk);
      while (!cfg_ready);
      key_pairs[i] = pairs[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Driver: a request is taken at an edge with start high and busy low.
  // The model runs at that edge, so it uses the key in force for the request.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cipher_due.push_back(gost_cipher(in_kind, in_data_block));
        accepted_count++;
      end
      // free to change the offer unless it is being held off by busy
      if (!start || !busy) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_blocks.pop_front();
          start         <= 1'b1;
          in_kind       <= next_req.kind;
          in_data_block <= next_req.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a strobed result is taken at the edge closing its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cipher_due.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result_block %h at %0t", out_result_block, $realtime);
        end
        fail_count++;
      end else begin
        want_block = cipher_due.pop_front();
        if (out_result_block !== want_block) begin
          if (fail_count < 10) begin
            $display("result_block mismatch at %0t: expected %h, got %h",
                     $realtime, want_block, out_result_block);
          end
          fail_count++;
        end
      end
    end
  end

  // Sequencer
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset key (all zero): field extremes both ways
    src_idle_pct = 10;
    queue_req(KIND_ENC, 64'h0);
    queue_req(KIND_DEC, 64'h0);
    queue_req(KIND_ENC, '1);
    queue_req(KIND_DEC, '1);
    queue_req(KIND_ENC, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(KIND_DEC, 64'h5555_5555_5555_5555);
    queue_req(KIND_ENC, 64'h0000_0000_FFFF_FFFF);
    queue_req(KIND_DEC, 64'hFFFF_FFFF_0000_0000);
    queue_req(KIND_ENC, 64'h0123_4567_89AB_CDEF);
    queue_req(KIND_DEC, 64'h0123_4567_89AB_CDEF);
    queue_req(KIND_ENC, 64'h8000_0000_0000_0001);
    queue_req(KIND_DEC, 64'h0000_0001_8000_0000);
    wait_drain();

    // All-ones key: every addition to a nonzero half carries out of 32 bits and must wrap
    load_key('1, '1, '1, '1);
    queue_req(KIND_ENC, 64'h0);
    queue_req(KIND_DEC, 64'h0);
    queue_req(KIND_ENC, '1);
    queue_req(KIND_DEC, '1);
    queue_req(KIND_ENC, 64'hFEDC_BA98_7654_3210);
    queue_req(KIND_DEC, gost_cipher(KIND_ENC, 64'hFEDC_BA98_7654_3210));
    wait_drain();

    // Random key, light sender gaps; sender stops halfway until all is back
    load_key({$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    queue_random(225);
    wait_drain();
    queue_random(225);
    wait_drain();

    // Fresh key, heavy sender gaps
    src_idle_pct = 78;
    load_key({$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    queue_random(450);
    wait_drain();

    // Mixed extreme/random key words, back-to-back requests
    src_idle_pct = 0;
    load_key({32'hFFFF_FFFF, 32'h0}, {32'h0, $urandom},
             {$urandom, 32'hFFFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF});
    queue_random(450);
    wait_drain();

    // stray strobes after the last result still count against us
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && cipher_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/gost_pkg.sv
hdl/gost_block_cipher_ecb.sv
tb/tb_gost_block_cipher_ecb.sv
